// ===== src/prc_pkg.sv =====
// Shared types and constants for the precision-recall curve point generator.
// Holds the item structs, point kind codes and sequencer states.
// No dependencies.
package prc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIX_W     = FRAC_BITS + 1;
  localparam int CNT_W     = 21;
  localparam int DEN_W     = CNT_W + 1;
  localparam int STEP_W    = $clog2(FRAC_BITS + 1);

  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(1 << 20);
  localparam logic [FIX_W-1:0] FIX_ONE   = FIX_W'(1) << FRAC_BITS;

  localparam logic [1:0] KIND_START     = 2'd0;
  localparam logic [1:0] KIND_THRESHOLD = 2'd1;
  localparam logic [1:0] KIND_FINAL     = 2'd2;

  localparam logic [1:0] TRUTH_EVENT    = 2'd1;
  localparam logic [1:0] TRUTH_NONEVENT = 2'd2;

  typedef struct packed {
    logic [FIX_W-1:0] score;
    logic [1:0]       truth_code;
    logic             last_item;
  } prc_in_t;

  typedef struct packed {
    logic [1:0]       point_kind;
    logic [FIX_W-1:0] threshold;
    logic [FIX_W-1:0] recall;
    logic [FIX_W-1:0] precision;
    logic             recall_undefined;
    logic             precision_undefined;
    logic             last_point;
  } prc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_REC,
    ST_DIV_PREC,
    ST_EMIT_THR,
    ST_COUNT,
    ST_DIV_FIN,
    ST_EMIT_FIN
  } prc_state_t;

endpackage

// ===== src/precision_recall_curve_points.sv =====
// A threshold point takes two quotients, recall and then precision, on the one
// shared restoring divider (16 steps each unless saturated or undefined); the
// final point takes one more quotient after the counting step. The start point
// is loaded from the check state and needs no division.
// The output register lets the next item in while a point waits to be taken.
// Reset (rst_n, synchronous, active low) clears the run state and the output valid flag.
module precision_recall_curve_points (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  prc_pkg::prc_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output prc_pkg::prc_out_t       out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [prc_pkg::CNT_W-1:0] cfg_data
);
  import prc_pkg::*;

  prc_state_t state_r, state_nxt;

  logic [CNT_W-1:0] pos_cnt_r;
  logic [CNT_W-1:0] tp_r, tp_nxt;
  logic [CNT_W-1:0] fp_r, fp_nxt;
  logic [CNT_W-1:0] items_r, items_nxt;
  logic [FIX_W-1:0] prev_score_r, prev_score_nxt;
  logic             started_r, started_nxt;

  prc_in_t          item_r;
  logic [FIX_W-1:0] rec_r, rec_nxt;
  logic             rec_undef_r, rec_undef_nxt;

  logic             out_valid_r, out_valid_nxt;
  prc_out_t         out_data_r, out_data_nxt;
  logic             out_load, out_free;

  // Shared divider: floor((num << FRAC_BITS) / den), saturated at one, zero and undefined when den is zero.
  logic [DEN_W-1:0]     div_rem_r, div_den_r;
  logic [FRAC_BITS-1:0] div_q_r;
  logic [STEP_W-1:0]    div_cnt_r;
  logic                 div_undef_r, div_sat_r;
  logic                 div_load, div_busy;
  logic [DEN_W-1:0]     div_num, div_den;
  logic [DEN_W:0]       div_shift, div_diff;
  logic                 div_ge;
  logic [FIX_W-1:0]     div_result;

  logic [CNT_W-1:0]     tp_bump, fp_bump, items_bump;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign div_busy   = (div_cnt_r != '0);
  assign div_shift  = {div_rem_r, 1'b0};
  assign div_diff   = div_shift - {1'b0, div_den_r};
  assign div_ge     = (div_shift >= {1'b0, div_den_r});
  assign div_result = div_undef_r ? '0 : (div_sat_r ? FIX_ONE : {1'b0, div_q_r});

  assign tp_bump    = (tp_r < CNT_MAX) ? tp_r + 1'b1 : tp_r;
  assign fp_bump    = (fp_r < CNT_MAX) ? fp_r + 1'b1 : fp_r;
  assign items_bump = (items_r < CNT_MAX) ? items_r + 1'b1 : items_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_cnt_r    <= '0;
      tp_r         <= '0;
      fp_r         <= '0;
      items_r      <= '0;
      prev_score_r <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      div_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      tp_r         <= tp_nxt;
      fp_r         <= fp_nxt;
      items_r      <= items_nxt;
      prev_score_r <= prev_score_nxt;
      started_r    <= started_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pos_cnt_r <= cfg_data;
      end
      if (div_load) begin
        div_cnt_r <= ((div_den == '0) || (div_num >= div_den)) ? '0 : STEP_W'(FRAC_BITS);
      end else if (div_busy) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    rec_r       <= rec_nxt;
    rec_undef_r <= rec_undef_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
    if (div_load) begin
      div_rem_r   <= div_num;
      div_den_r   <= div_den;
      div_q_r     <= '0;
      div_undef_r <= (div_den == '0);
      div_sat_r   <= (div_den != '0) && (div_num >= div_den);
    end else if (div_busy) begin
      div_rem_r <= div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
      div_q_r   <= {div_q_r[FRAC_BITS-2:0], div_ge};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    tp_nxt         = tp_r;
    fp_nxt         = fp_r;
    items_nxt      = items_r;
    prev_score_nxt = prev_score_r;
    started_nxt    = started_r;
    rec_nxt        = rec_r;
    rec_undef_nxt  = rec_undef_r;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    div_load       = 1'b0;
    div_num        = {1'b0, tp_r};
    div_den        = {1'b0, pos_cnt_r};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!started_r) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_data_nxt = '{point_kind: KIND_START, threshold: '0, recall: '0,
                             precision: FIX_ONE, recall_undefined: 1'b0,
                             precision_undefined: 1'b0, last_point: 1'b0};
            started_nxt    = 1'b1;
            prev_score_nxt = item_r.score;
            state_nxt      = ST_COUNT;
          end
        end else if (item_r.score != prev_score_r) begin
          div_load  = 1'b1;
          state_nxt = ST_DIV_REC;
        end else begin
          state_nxt = ST_COUNT;
        end
      end
      ST_DIV_REC: begin
        if (!div_busy) begin
          rec_nxt       = div_result;
          rec_undef_nxt = div_undef_r;
          div_load      = 1'b1;
          div_num       = {1'b0, tp_r};
          div_den       = {1'b0, tp_r} + {1'b0, fp_r};
          state_nxt     = ST_DIV_PREC;
        end
      end
      ST_DIV_PREC: begin
        if (!div_busy) begin
          state_nxt = ST_EMIT_THR;
        end
      end
      ST_EMIT_THR: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{point_kind: KIND_THRESHOLD, threshold: prev_score_r,
                           recall: rec_r, precision: div_result,
                           recall_undefined: rec_undef_r,
                           precision_undefined: div_undef_r, last_point: 1'b0};
          prev_score_nxt = item_r.score;
          state_nxt      = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (item_r.truth_code == TRUTH_EVENT) begin
          tp_nxt = tp_bump;
        end else if (item_r.truth_code == TRUTH_NONEVENT) begin
          fp_nxt = fp_bump;
        end
        items_nxt = items_bump;
        if (item_r.last_item) begin
          div_load  = 1'b1;
          div_num   = {1'b0, pos_cnt_r};
          div_den   = {1'b0, items_bump};
          state_nxt = ST_DIV_FIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_FIN: begin
        if (!div_busy) begin
          state_nxt = ST_EMIT_FIN;
        end
      end
      ST_EMIT_FIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{point_kind: KIND_FINAL, threshold: prev_score_r,
                           recall: (pos_cnt_r != '0) ? FIX_ONE : '0,
                           precision: div_result,
                           recall_undefined: (pos_cnt_r == '0),
                           precision_undefined: div_undef_r, last_point: 1'b1};
          // The run ends here; the next item opens a new one.
          tp_nxt         = '0;
          fp_nxt         = '0;
          items_nxt      = '0;
          prev_score_nxt = '0;
          started_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

endmodule

// ===== src/prc_checker.sv =====
// Port-level checks for the precision-recall curve point generator.
// Depends on prc_pkg; bound to the top level at the end of this file.
module prc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input prc_pkg::prc_in_t          in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input prc_pkg::prc_out_t         out_data,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [prc_pkg::CNT_W-1:0] cfg_data
);
  import prc_pkg::*;

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Every item keeps the input stalled in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // The register is written only while no item is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !in_stall)
    else $error("configuration write while busy");

  // A new result only comes out of work on an accepted item.
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a busy cycle");

endmodule

bind precision_recall_curve_points prc_checker u_prc_checker (.*);
